>>> rtl/rppr_pkg.sv
//------------------------------------------------------------------------------
// rppr_pkg
// Shared types and constants for the rational perfect power root core.
//------------------------------------------------------------------------------
package rppr_pkg;

   localparam int FIELD_WIDTH      = 64;
   localparam int EXP_WIDTH        = 7;
   localparam int MAX_SEARCH_POWER = 63;

   typedef enum logic [0:0] {
      OP_ROOT   = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   typedef struct packed {
      op_type                   operation;
      logic [FIELD_WIDTH-1:0]   numerator;
      logic [FIELD_WIDTH-1:0]   denominator;
      logic [EXP_WIDTH-1:0]     exponent;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic [EXP_WIDTH-1:0]     power;
      logic [FIELD_WIDTH-1:0]   root_numerator;
      logic [FIELD_WIDTH-1:0]   root_denominator;
   } rsp_type;

   // Sequencer states for one integer root.
   typedef enum logic [3:0] {
      RS_IDLE,
      RS_SHIFT,
      RS_PSTART,
      RS_MLO,
      RS_MHI,
      RS_PDONE,
      RS_DIV1,
      RS_STEP,
      RS_DIV2
   } root_state_type;

   // Top-level sequencer states.
   typedef enum logic [2:0] {
      TS_IDLE,
      TS_NSTART,
      TS_NUM,
      TS_DEN,
      TS_NEXT,
      TS_OUT
   } top_state_type;

endpackage

>>> rtl/rppr_div.sv
//------------------------------------------------------------------------------
// rppr_div
// Radix-2 restoring divider: one quotient bit per cycle.
//------------------------------------------------------------------------------
module rppr_div import rppr_pkg::*; #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = CW'(W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff)) else $error("divider done without run");
   a_no_run_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff) else $error("divider still running at done");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (cnt_ff != '0)) else $error("divider counter underflow");
`endif

endmodule

>>> rtl/rppr_root.sv
//------------------------------------------------------------------------------
// rppr_root
// Exact integer n-th root: Newton iteration with a saturating power unit
// and a shared serial divider, then a power check of the final guess.
//------------------------------------------------------------------------------
module rppr_root import rppr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [FIELD_WIDTH-1:0] value,
   input  logic [EXP_WIDTH-1:0]   degree,
   output logic                   done,
   output logic                   ok,
   output logic [FIELD_WIDTH-1:0] root
);
   localparam int W  = FIELD_WIDTH;
   localparam int HW = W / 2;
   localparam int LW = $clog2(W + 1);
   localparam int RW = LW + 1;
   localparam int SW = $clog2(HW + 1);
   localparam int TW = HW + 1 + EXP_WIDTH;

   function automatic logic [LW-1:0] bit_len(input logic [W-1:0] v);
      logic [LW-1:0] n;
      n = '0;
      for (int i = 0; i < W; i++) begin
         if (v[i]) n = LW'(i + 1);
      end
      return n;
   endfunction

   root_state_type       state_ff, state_in;
   logic [W-1:0]         a_ff, a_in, g_ff, g_in, acc_ff, acc_in;
   logic [W-1:0]         plo_ff, plo_in, q_ff, q_in, root_ff, root_in;
   logic [EXP_WIDTH-1:0] n_ff, n_in, pc_ff, pc_in;
   logic                 ovf_ff, ovf_in, chk_ff, chk_in, ok_ff, ok_in;
   logic                 done_ff, done_in;
   logic [SW-1:0]        sh_ff, sh_in;
   logic [RW-1:0]        rest_ff, rest_in;

   // Shared divider.
   logic         dv_start, dv_done;
   logic [W-1:0] dv_a, dv_b, dv_q;

   rppr_div #(.W(W)) u_div (
      .clock(clock), .reset(reset), .start(dv_start),
      .dividend(dv_a), .divisor(dv_b), .done(dv_done), .quotient(dv_q)
   );

   logic [W-1:0]  g_one;
   logic          trivial;
   logic [HW-1:0] mul_a;
   logic [W-1:0]  mprod;
   logic [W:0]    msum;
   logic [W-1:0]  mres;
   logic          movf;
   logic          pow_last;
   logic          shift_more;
   logic [TW-1:0] tmul;
   logic [W:0]    tsum;

   assign g_one   = {{(W-1){1'b0}}, 1'b1};
   assign trivial = (degree <= EXP_WIDTH'(1)) || (value <= g_one);

   // One 32x32 multiplier: low half of acc, then high half, times the guess.
   assign mul_a = (state_ff == RS_MHI) ? acc_ff[W-1:HW] : acc_ff[HW-1:0];
   assign mprod = W'(mul_a) * W'(g_ff[HW-1:0]);
   assign msum  = {1'b0, plo_ff} + {1'b0, mprod[HW-1:0], {HW{1'b0}}};

   // The guess never exceeds 2^32; that one value is a plain shift.
   always_comb begin
      if (g_ff[HW]) begin
         mres = {acc_ff[HW-1:0], {HW{1'b0}}};
         movf = |acc_ff[W-1:HW];
      end else begin
         mres = msum[W-1:0];
         movf = (|mprod[W-1:HW]) | msum[W];
      end
   end

   assign pow_last   = movf || (pc_ff == EXP_WIDTH'(1));
   assign shift_more = (rest_ff >= RW'(n_ff));
   assign tmul       = TW'(g_ff[HW:0]) * TW'(n_ff - EXP_WIDTH'(1));
   assign tsum       = {1'b0, q_ff} + (W+1)'(tmul);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         RS_IDLE:   if (start && !trivial) state_in = RS_SHIFT;
         RS_SHIFT:  if (!shift_more) state_in = RS_PSTART;
         RS_PSTART: state_in = RS_MLO;
         RS_MLO:    state_in = RS_MHI;
         RS_MHI:    state_in = pow_last ? RS_PDONE : RS_MLO;
         RS_PDONE: begin
            if (chk_ff) state_in = RS_IDLE;
            else if (ovf_ff) state_in = RS_STEP;
            else state_in = RS_DIV1;
         end
         RS_DIV1:   if (dv_done) state_in = RS_STEP;
         RS_STEP:   state_in = RS_DIV2;
         RS_DIV2:   if (dv_done) state_in = RS_PSTART;
         default:   state_in = RS_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      a_in    = a_ff;
      n_in    = n_ff;
      g_in    = g_ff;
      acc_in  = acc_ff;
      plo_in  = plo_ff;
      q_in    = q_ff;
      pc_in   = pc_ff;
      ovf_in  = ovf_ff;
      chk_in  = chk_ff;
      sh_in   = sh_ff;
      rest_in = rest_ff;
      ok_in   = ok_ff;
      root_in = root_ff;
      done_in = 1'b0;
      dv_start = 1'b0;
      dv_a     = a_ff;
      dv_b     = acc_ff;
      case (state_ff)
         RS_IDLE: if (start) begin
            a_in    = value;
            n_in    = degree;
            chk_in  = 1'b0;
            sh_in   = '0;
            rest_in = RW'(bit_len(value)) + RW'(degree) - RW'(1);
            // Zero degree gives one; degree one, zero and one pass through.
            if (trivial) begin
               done_in = 1'b1;
               ok_in   = 1'b1;
               root_in = (degree == '0) ? g_one : value;
            end
         end
         RS_SHIFT: begin
            // Start guess 2^ceil(len/n) by repeated subtraction.
            if (shift_more) begin
               rest_in = rest_ff - RW'(n_ff);
               sh_in   = sh_ff + SW'(1);
            end else begin
               g_in = g_one << sh_ff;
            end
         end
         RS_PSTART: begin
            acc_in = g_one;
            ovf_in = 1'b0;
            pc_in  = chk_ff ? n_ff : n_ff - EXP_WIDTH'(1);
         end
         RS_MLO: plo_in = mprod;
         RS_MHI: begin
            pc_in = pc_ff - EXP_WIDTH'(1);
            if (movf) ovf_in = 1'b1;
            else acc_in = mres;
         end
         RS_PDONE: begin
            if (chk_ff) begin
               done_in = 1'b1;
               ok_in   = !ovf_ff && (acc_ff == a_ff);
               root_in = g_ff;
            end else if (ovf_ff) begin
               // Overflowed power: quotient is zero, skip the division.
               q_in = '0;
            end else begin
               dv_start = 1'b1;
            end
         end
         RS_DIV1: if (dv_done) q_in = dv_q;
         RS_STEP: begin
            dv_start = 1'b1;
            dv_a     = tsum[W] ? {W{1'b1}} : tsum[W-1:0];
            dv_b     = W'(n_ff);
         end
         RS_DIV2: if (dv_done) begin
            if (dv_q < g_ff) g_in = dv_q;
            else chk_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      a_ff    <= a_in;
      n_ff    <= n_in;
      g_ff    <= g_in;
      acc_ff  <= acc_in;
      plo_ff  <= plo_in;
      q_ff    <= q_in;
      pc_ff   <= pc_in;
      ovf_ff  <= ovf_in;
      chk_ff  <= chk_in;
      sh_ff   <= sh_in;
      rest_ff <= rest_in;
      ok_ff   <= ok_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign ok   = ok_ff;
   assign root = root_ff;

`ifndef SYNTHESIS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (state_ff == RS_IDLE)) else $error("done outside idle");
   a_guess_falls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RS_DIV2 && dv_done && (dv_q < g_ff)) |=> (g_ff < $past(g_ff)))
      else $error("Newton guess did not fall");
   a_guess_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RS_MLO) |-> (g_ff <= {{(W-HW-1){1'b0}}, 1'b1, {HW{1'b0}}}))
      else $error("guess above 2^32");
`endif

endmodule

>>> rtl/rational_perfect_power_root_core.sv
//------------------------------------------------------------------------------
// rational_perfect_power_root_core
// Exact n-th root of a reduced rational, or search for its largest exact power.
//------------------------------------------------------------------------------
// Usage:
//   Drive req_item and raise start while busy is low; the item is taken at
//   that edge and busy stays high until the result cycle has passed. One
//   item is in flight at a time. Operation 0 takes the root of the given
//   degree; operation 1 tries degrees from min(MAX_SEARCH_POWER, exponent)
//   down to 2 and returns the first exact one.
//   Each part's root runs through one sequencer. Degree 0 or 1, or a part of
//   0 or 1, is answered straight from idle. Otherwise the start guess comes
//   from repeated subtraction, and each Newton step takes the power of the
//   guess (up to degree-1 multiplies, fewer once the power overflows) and
//   two serial divisions, the first skipped when the power overflows. A final
//   power check of the guess then follows. A full search repeats this for up
//   to 62 degrees.
//   Operation 1 with a limit below 2 answers in the cycle after accept.
//   The result appears on rsp_item for exactly one cycle with rsp_valid
//   high; the receiver cannot stall, so it must take it then. A synchronous
//   reset drops any item in flight and returns the block to idle.
//------------------------------------------------------------------------------
module rational_perfect_power_root_core import rppr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);
   top_state_type          state_ff, state_in;
   op_type                 op_ff;
   logic [FIELD_WIDTH-1:0] num_ff, den_ff, rn_ff, rn_in;
   logic [EXP_WIDTH-1:0]   k_ff, k_in, ex_ff;
   rsp_type                out_ff, out_in;

   logic                   rt_start, rt_done, rt_ok;
   logic [FIELD_WIDTH-1:0] rt_val, rt_root;

   rppr_root u_root (
      .clock(clock), .reset(reset), .start(rt_start), .value(rt_val),
      .degree(k_ff), .done(rt_done), .ok(rt_ok), .root(rt_root)
   );

   logic accept;
   assign accept = start && !busy;

   logic [EXP_WIDTH-1:0] k_first;
   assign k_first = (req_item.exponent < EXP_WIDTH'(MAX_SEARCH_POWER)) ?
                    req_item.exponent : EXP_WIDTH'(MAX_SEARCH_POWER);

   // Another degree is left to try in a search.
   logic more_degrees;
   assign more_degrees = (op_ff == OP_SEARCH) && (k_ff > EXP_WIDTH'(2));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TS_IDLE: if (accept) begin
            if (req_item.operation == OP_SEARCH && k_first < EXP_WIDTH'(2))
               state_in = TS_OUT;
            else state_in = TS_NSTART;
         end
         TS_NSTART: state_in = TS_NUM;
         TS_NUM: if (rt_done) state_in = rt_ok ? TS_DEN : TS_NEXT;
         TS_DEN: if (rt_done) state_in = rt_ok ? TS_OUT : TS_NEXT;
         TS_NEXT: state_in = more_degrees ? TS_NSTART : TS_OUT;
         TS_OUT: state_in = TS_IDLE;
         default: state_in = TS_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      rt_start = 1'b0;
      rt_val   = num_ff;
      k_in     = k_ff;
      rn_in    = rn_ff;
      out_in   = out_ff;
      case (state_ff)
         TS_IDLE: if (accept) begin
            // Load the first degree; a search with no degree returns the input.
            k_in = (req_item.operation == OP_SEARCH) ? k_first : req_item.exponent;
            out_in.found            = 1'b1;
            out_in.power            = EXP_WIDTH'(1);
            out_in.root_numerator   = req_item.numerator;
            out_in.root_denominator = req_item.denominator;
         end
         TS_NSTART: rt_start = 1'b1;
         TS_NUM: if (rt_done && rt_ok) begin
            // Hold the numerator root and start on the denominator.
            rn_in    = rt_root;
            rt_start = 1'b1;
            rt_val   = den_ff;
         end
         TS_DEN: if (rt_done && rt_ok) begin
            out_in.found            = 1'b1;
            out_in.power            = k_ff;
            out_in.root_numerator   = rn_ff;
            out_in.root_denominator = rt_root;
         end
         TS_NEXT: begin
            if (more_degrees) begin
               k_in = k_ff - EXP_WIDTH'(1);
            end else if (op_ff == OP_ROOT) begin
               out_in.found            = 1'b0;
               out_in.power            = ex_ff;
               out_in.root_numerator   = '0;
               out_in.root_denominator = '0;
            end else begin
               out_in.found            = 1'b1;
               out_in.power            = EXP_WIDTH'(1);
               out_in.root_numerator   = num_ff;
               out_in.root_denominator = den_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff   <= k_in;
      rn_ff  <= rn_in;
      out_ff <= out_in;
      if (accept) begin
         op_ff  <= req_item.operation;
         num_ff <= req_item.numerator;
         den_ff <= req_item.denominator;
         ex_ff  <= req_item.exponent;
      end
   end

   assign busy      = (state_ff != TS_IDLE);
   assign rsp_valid = (state_ff == TS_OUT);
   assign rsp_item  = out_ff;

`ifndef SYNTHESIS
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held over a cycle");
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("accept did not raise busy");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rational perfect power root core.
//------------------------------------------------------------------------------
// Items go in through the start/busy handshake. Each accepted item is run
// through a local model of the exact root and largest power search. The
// model's answer is queued and later compared field by field with the strobed
// result. Stimulus starts with directed corner cases. Random perfect powers,
// searches and malformed values follow, under three sender idle patterns.
//------------------------------------------------------------------------------
module tb_top;
   import rppr_pkg::*;

   localparam longint unsigned ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int              SEARCH_TOP  = 63;
   localparam longint          CYCLE_LIMIT = 200_000_000;
   localparam int              DRAIN_WAIT  = 200;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   rsp_type expected_roots[$];
   int      mismatches;
   int      items_sent;
   int      results_seen;
   int      searches_sent;
   int      sender_idle_pct;
   longint  cycle_count;

   rational_perfect_power_root_core u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   //---------------------------------------------------------------------------
   // Root model
   //---------------------------------------------------------------------------

   // Power with saturation: overflow is flagged and the top value returned.
   function automatic longint unsigned sat_power(input longint unsigned base,
                                                 input longint unsigned degree,
                                                 output bit overflow);
      longint unsigned acc;
      acc = 1;
      overflow = 1'b0;
      for (longint unsigned i = 0; i < degree; i++) begin
         if (base != 0 && acc > ALL_ONES / base) begin
            overflow = 1'b1;
            return ALL_ONES;
         end
         acc = acc * base;
      end
      return acc;
   endfunction

   function automatic int unsigned bit_length(input longint unsigned v);
      int unsigned n;
      n = 0;
      while (v != 0) begin
         n++;
         v = v >> 1;
      end
      return n;
   endfunction

   // Exact integer n-th root by Newton steps from a power of two above it.
   function automatic bit exact_int_root(input longint unsigned a,
                                         input longint unsigned n,
                                         output longint unsigned root);
      longint unsigned guess, step_guess, p, q, t;
      int unsigned     sh;
      bit              ovf;
      root = 0;
      if (n == 0) begin
         root = 1;
         return 1'b1;
      end
      if (n == 1 || a <= 1) begin
         root = a;
         return 1'b1;
      end
      sh = (bit_length(a) + n - 1) / n;
      step_guess = 64'd1 << sh;
      do begin
         guess = step_guess;
         p = sat_power(guess, n - 1, ovf);
         q = ovf ? 64'd0 : a / p;
         t = (n - 1) * guess;
         if (q > ALL_ONES - t)
            step_guess = ALL_ONES / n;
         else
            step_guess = (q + t) / n;
      end while (step_guess < guess);
      p = sat_power(guess, n, ovf);
      if (!ovf && p == a) begin
         root = guess;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit rational_root(input longint unsigned num,
                                        input longint unsigned den,
                                        input longint unsigned n,
                                        output longint unsigned rn,
                                        output longint unsigned rd);
      rd = 0;
      if (!exact_int_root(num, n, rn)) return 1'b0;
      if (!exact_int_root(den, n, rd)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic rsp_type predict_root(input req_type r);
      rsp_type         res;
      longint unsigned rn, rd;
      int              k;
      res = '0;
      if (r.operation == OP_ROOT) begin
         res.power = r.exponent;
         if (rational_root(r.numerator, r.denominator, r.exponent, rn, rd)) begin
            res.found            = 1'b1;
            res.root_numerator   = rn;
            res.root_denominator = rd;
         end
         return res;
      end
      // Search the largest degree first and stop at the first exact one.
      k = (r.exponent < SEARCH_TOP) ? r.exponent : SEARCH_TOP;
      for (; k >= 2; k--) begin
         if (rational_root(r.numerator, r.denominator, k, rn, rd)) begin
            res.found            = 1'b1;
            res.power            = k[EXP_WIDTH-1:0];
            res.root_numerator   = rn;
            res.root_denominator = rd;
            return res;
         end
      end
      res.found            = 1'b1;
      res.power            = 1;
      res.root_numerator   = r.numerator;
      res.root_denominator = r.denominator;
      return res;
   endfunction

   //---------------------------------------------------------------------------
   // Driving
   //---------------------------------------------------------------------------

   function automatic longint unsigned rand64();
      return {$urandom, $urandom};
   endfunction

   // Random b^k that fits in 64 bits; base limited to floor(64/k) bits.
   function automatic longint unsigned rand_perfect_power(input int k,
                                                          output longint unsigned base);
      int  bits;
      bit  ovf;
      bits = 64 / k;
      base = rand64() >> (64 - bits);
      if ($urandom_range(0, 3) == 0) base = base | (64'd1 << (bits - 1));
      return sat_power(base, k, ovf);
   endfunction

   // Hold the item with start high until taken; start stays high on return,
   // unless a random gap is taken, so that back-to-back items need only one assignment per step.
   task automatic send_item(input op_type op, input longint unsigned num,
                            input longint unsigned den, input int unsigned ex);
      req_type r;
      int      gap;
      r.operation   = op;
      r.numerator   = num;
      r.denominator = den;
      r.exponent    = ex[EXP_WIDTH-1:0];
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      expected_roots.push_back(predict_root(r));
      items_sent++;
      if (op == OP_SEARCH) searches_sent++;
      // Drop start for a random gap now and then.
      if ($urandom_range(1, 100) <= sender_idle_pct) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   //---------------------------------------------------------------------------
   // Tests
   //---------------------------------------------------------------------------

   task automatic test_special_cases();
      send_item(OP_ROOT,   0, 1, 0);                      // zero exponent
      send_item(OP_ROOT,   12345, 678, 0);
      send_item(OP_ROOT,   ALL_ONES, ALL_ONES, 1);        // exponent one
      send_item(OP_ROOT,   0, 1, 5);                      // part of zero
      send_item(OP_ROOT,   1, 1, 127);                    // part of one
      send_item(OP_ROOT,   ALL_ONES, 1, 2);               // no exact root
      send_item(OP_ROOT,   64'hFFFF_FFFE_0000_0001, 1, 2);// (2^32-1)^2
      send_item(OP_ROOT,   64'd12157665459056928801, 64'h100_0000_0000, 40);
      send_item(OP_ROOT,   8, 3, 3);                      // denominator fails
      send_item(OP_ROOT,   4, 0, 2);                      // zero denominator
      send_item(OP_ROOT,   ALL_ONES, 1, 63);              // power overflow
      send_item(OP_ROOT,   ALL_ONES, ALL_ONES, 64);
      send_item(OP_ROOT,   64'h8000_0000_0000_0000, 1, 63);
      send_item(OP_SEARCH, 9, 4, 0);                      // no search below two
      send_item(OP_SEARCH, 9, 4, 1);
      send_item(OP_SEARCH, 64'h8000_0000_0000_0000, 1, 127);
      send_item(OP_SEARCH, 64, 1, 63);
      send_item(OP_SEARCH, 1, 1, 63);
      send_item(OP_SEARCH, 7, 11, 63);                    // full search, no hit
      send_item(OP_SEARCH, 0, ALL_ONES, 2);
   endtask

   // Mostly true rational powers; the degree asked is the true one, a
   // divisor of it, or a neighbor.
   task automatic test_exact_roots(input int count);
      longint unsigned num, den, b1, b2;
      int              k, ex;
      for (int i = 0; i < count; i++) begin
         k   = $urandom_range(2, 20);
         num = rand_perfect_power(k, b1);
         den = rand_perfect_power(k, b2);
         if (den == 0) den = 1;
         case ($urandom_range(0, 3))
            0:       ex = k + 1;
            1:       ex = (k % 2 == 0) ? k / 2 : k;
            default: ex = k;
         endcase
         send_item(OP_ROOT, num, den, ex);
      end
   endtask

   // Searches over true powers; a few go from the top degree down.
   task automatic test_power_search(input int count);
      longint unsigned num, den, b1, b2;
      int              k, ex;
      for (int i = 0; i < count; i++) begin
         k   = $urandom_range(2, 12);
         num = rand_perfect_power(k, b1);
         den = rand_perfect_power(k, b2);
         if (den == 0) den = 1;
         ex  = ($urandom_range(0, 7) == 0) ? $urandom_range(63, 127)
                                           : $urandom_range(k, k + 6);
         send_item(OP_SEARCH, num, den, ex);
      end
   endtask

   // Arbitrary values: almost never perfect powers.
   task automatic test_malformed_inputs(input int count);
      longint unsigned den;
      op_type          op;
      for (int i = 0; i < count; i++) begin
         den = rand64();
         if (den == 0) den = 1;
         op = op_type'($urandom_range(0, 1));
         if (op == OP_ROOT)
            send_item(op, rand64(), den, $urandom_range(0, 127));
         else
            send_item(op, rand64(), den,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(0, 6));
      end
   endtask

   //---------------------------------------------------------------------------
   // Result check
   //---------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_roots.size() == 0) begin
            $error("result with no item outstanding: %p", rsp_item);
            mismatches++;
         end else begin
            want = expected_roots.pop_front();
            if (rsp_item.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_item.found);
               mismatches++;
            end
            if (rsp_item.power !== want.power) begin
               $error("power: expected %0d, got %0d", want.power, rsp_item.power);
               mismatches++;
            end
            if (rsp_item.root_numerator !== want.root_numerator) begin
               $error("root_numerator: expected %h, got %h",
                      want.root_numerator, rsp_item.root_numerator);
               mismatches++;
            end
            if (rsp_item.root_denominator !== want.root_denominator) begin
               $error("root_denominator: expected %h, got %h",
                      want.root_denominator, rsp_item.root_denominator);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_roots.size());
         $display("FAIL");
         $finish;
      end
   end

   //---------------------------------------------------------------------------
   // Sequence
   //---------------------------------------------------------------------------

   initial begin
      int idle_pattern[3];
      idle_pattern = '{6, 88, 0};
      mismatches      = 0;
      items_sent      = 0;
      results_seen    = 0;
      searches_sent   = 0;
      cycle_count     = 0;
      sender_idle_pct = 0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_cases();
      // Sweep the idle patterns over the random parts.
      foreach (idle_pattern[p]) begin
         sender_idle_pct = idle_pattern[p];
         test_exact_roots(14);
         test_power_search(14);
         test_malformed_inputs(12);
      end
      start <= 1'b0;

      // Drain the pipeline, then let the bench idle before the summary.
      while (expected_roots.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d items (%0d searches), %0d results checked in %0d cycles",
               items_sent, searches_sent, results_seen, cycle_count);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
